[rtl/ctb_pkg.sv]
// Shared types, constants and the seven-segment encoder for the countdown timer.
// No dependencies; every other file imports it.
`default_nettype none

package ctb_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  localparam int SecW   = 7;
  localparam int TickW  = 8;
  localparam int SegW   = 8;
  localparam int DigitW = 4;

  localparam logic [1:0] BTN_RELEASED = 2'b11;

  localparam logic [7:0] RECIP_TEN   = 8'd205;
  localparam int         RECIP_SHIFT = 11;

  localparam logic [0:0] REG_PRESCALE = 1'b0;
  localparam logic [0:0] REG_MAX      = 1'b1;

  typedef struct packed {
    op_t  op;
    logic up;
    logic down;
  } item_t;

  typedef struct packed {
    logic            running;
    logic            buzzer;
    logic [SegW-1:0] tens_segments;
    logic [SegW-1:0] ones_segments;
    logic [SecW-1:0] remaining;
  } result_t;

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/ctb_core.sv]
// Timer state registers and the per-event next-state logic.
// Depends on ctb_pkg.
`default_nettype none

module ctb_core
  import ctb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire item_t            item,
  input  wire logic [TickW-1:0] prescale_threshold,
  input  wire logic [SecW-1:0]  max_setting,
  output logic      [SecW-1:0]  seconds_next,
  output logic                  buzz_next,
  output logic                  run_next
);

  logic [SecW-1:0]  seconds_left;
  logic [TickW-1:0] tick_count;
  logic             run_flag;
  logic             buzz_flag;
  logic [1:0]       last_buttons;

  logic [TickW-1:0] tick_next;
  logic [1:0]       buttons_next;
  logic [1:0]       pat;

  always_comb begin
    seconds_next = seconds_left;
    tick_next    = tick_count;
    run_next     = run_flag;
    buzz_next    = buzz_flag;
    buttons_next = last_buttons;
    pat          = {item.down, item.up};
    case (item.op)
      OP_TICK: begin
        if (run_flag) begin
          if (tick_count > prescale_threshold) begin
            tick_next = '0;
            if (seconds_left != '0) begin
              seconds_next = seconds_left - SecW'(1);
            end else begin
              buzz_next = 1'b1;
            end
          end else begin
            tick_next = tick_count + TickW'(1);
          end
        end
      end
      OP_START: begin
        run_next = 1'b1;
      end
      OP_STOP: begin
        run_next  = 1'b0;
        buzz_next = 1'b0;
      end
      OP_SAMPLE: begin
        if (pat == BTN_RELEASED) begin
          buttons_next = BTN_RELEASED;
        end else if (pat != last_buttons) begin
          buttons_next = pat;
          if (!item.up) begin
            if (seconds_left < max_setting) begin
              seconds_next = seconds_left + SecW'(1);
            end
          end else if (seconds_left != '0) begin
            seconds_next = seconds_left - SecW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_left <= '0;
      tick_count   <= '0;
      run_flag     <= 1'b0;
      buzz_flag    <= 1'b0;
      last_buttons <= BTN_RELEASED;
    end else if (step) begin
      seconds_left <= seconds_next;
      tick_count   <= tick_next;
      run_flag     <= run_next;
      buzz_flag    <= buzz_next;
      last_buttons <= buttons_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ctb_digits.sv]
// Splits the seconds value into two decimal digits and encodes both for the display.
// Depends on ctb_pkg.
`default_nettype none

module ctb_digits
  import ctb_pkg::*;
(
  input  wire logic [SecW-1:0] value,
  output logic      [SegW-1:0] ones_segments,
  output logic      [SegW-1:0] tens_segments
);

  logic [SecW+7:0]   prod;
  logic [DigitW-1:0] quot;
  logic [SecW-1:0]   quot_x10;
  logic [DigitW-1:0] ones_digit;
  logic [DigitW-1:0] tens_digit;

  always_comb begin
    prod       = (SecW+8)'(value) * (SecW+8)'(RECIP_TEN);
    quot       = prod[RECIP_SHIFT +: DigitW];
    quot_x10   = SecW'({quot, 3'b000}) + SecW'({quot, 1'b0});
    ones_digit = DigitW'(value - quot_x10);
    tens_digit = (quot >= DigitW'(10)) ? quot - DigitW'(10) : quot;
    ones_segments = seg_of(ones_digit);
    tens_segments = seg_of(tens_digit);
  end

endmodule

`default_nettype wire

[rtl/ctb_out_reg.sv]
// Result register on the master side; holds a result until the receiver takes it.
// Depends on ctb_pkg.
`default_nettype none

module ctb_out_reg
  import ctb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result_in,
  input  wire logic    take,
  output logic         valid,
  output result_t      result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

[rtl/countdown_timer_buzzer.sv]
// Two-digit countdown timer with buzzer, top level.
// Depends on ctb_pkg, ctb_core, ctb_digits and ctb_out_reg.
//
// Usage:
//   Each request on the slave side is one event: tick, start, stop or a
//   button sample (operation in s_axis_tuser). Each event yields exactly one
//   result on the master side with the seconds value, both active-low digit
//   patterns, and the buzzer and running flags after the event.
//   The cfg channel writes prescale_threshold (index 0) and max_setting
//   (index 1); cfg_ready is always high. Write only while the block is idle.
// Data path and throughput:
//   A request is held in the input register; when no result is pending or the
//   pending result is taken, the next-state logic and the digit encoder update the
//   state and load the result register. One request per cycle is sustained while
//   m_axis_tready is high; the single state update per event sets that rate.
// Reset:
//   rst clears the value, prescaler, run and buzzer flags, marks both buttons
//   released and restores threshold 15 and max setting 99. No result pending.
// Stall:
//   While m_axis_tready is low the result holds; one more request still
//   enters the input register, after which s_axis_tready drops.
`default_nettype none

module countdown_timer_buzzer
  import ctb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] button_up_level, [1] button_down_level
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [6:0] remaining, [14:7] ones_segments,
                                           // [22:15] tens_segments, [23] buzzer,
                                           // [24] running
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [TickW-1:0] prescale_threshold;
  logic [SecW-1:0]  max_setting;

  logic    in_valid;
  item_t   in_item;
  logic    advance;

  logic [SecW-1:0] seconds_next;
  logic            buzz_next;
  logic            run_next;
  logic [SegW-1:0] ones_seg;
  logic [SegW-1:0] tens_seg;
  result_t         result_next;
  result_t         result;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_threshold <= TickW'(15);
      max_setting        <= SecW'(99);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESCALE: prescale_threshold <= cfg_data;
        REG_MAX:      max_setting        <= cfg_data[SecW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= '{op: op_t'(s_axis_tuser), up: s_axis_tdata[0], down: s_axis_tdata[1]};
    end
  end

  ctb_core u_core (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .item               (in_item),
    .prescale_threshold (prescale_threshold),
    .max_setting        (max_setting),
    .seconds_next       (seconds_next),
    .buzz_next          (buzz_next),
    .run_next           (run_next)
  );

  ctb_digits u_digits (
    .value         (seconds_next),
    .ones_segments (ones_seg),
    .tens_segments (tens_seg)
  );

  assign result_next = '{running:       run_next,
                         buzzer:        buzz_next,
                         tens_segments: tens_seg,
                         ones_segments: ones_seg,
                         remaining:     seconds_next};

  ctb_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (result_next),
    .take      (m_axis_tready),
    .valid     (m_axis_tvalid),
    .result    (result)
  );

  assign m_axis_tdata = {7'd0, result};

endmodule

`default_nettype wire

[rtl/ctb_checker.sv]
// Port-level checks for the countdown timer, bound to the top level.
// Depends on ctb_pkg and countdown_timer_buzzer.
`default_nettype none

module ctb_port_checks
  import ctb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  logic [DigitW-1:0] chk_ones;
  logic [DigitW-1:0] chk_tens;
  logic [SecW+7:0]   chk_prod;
  logic [DigitW-1:0] chk_quot;

  always_comb begin
    chk_prod = (SecW+8)'(m_axis_tdata[6:0]) * (SecW+8)'(RECIP_TEN);
    chk_quot = chk_prod[RECIP_SHIFT +: DigitW];
    chk_ones = DigitW'(m_axis_tdata[6:0] - (SecW'({chk_quot, 3'b000}) + SecW'({chk_quot, 1'b0})));
    chk_tens = (chk_quot >= DigitW'(10)) ? chk_quot - DigitW'(10) : chk_quot;
  end

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_segments_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[14:7] == seg_of(chk_ones)
                      && m_axis_tdata[22:15] == seg_of(chk_tens))
    else $error("segment patterns disagree with remaining");

  a_buzz_while_running: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[24])
    else $error("buzzer sounding while stopped");

endmodule

bind countdown_timer_buzzer ctb_port_checks u_ctb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/ctb_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for countdown_timer_buzzer: tracks config writes, predicts the display for
// each accepted event request and compares it with every accepted result. Depends on ctb_pkg.
module ctb_checker
  import ctb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);

  // active-low digit patterns, digit 0 in the lowest byte
  localparam logic [79:0] DigitPatterns = {
    8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  logic [TickW-1:0] threshold;
  logic [SecW-1:0]  max_setting;
  logic [SecW-1:0]  seconds_left;
  logic [TickW-1:0] tick_count;
  logic             run_flag;
  logic             buzz_flag;
  logic [1:0]       last_buttons;

  result_t pending_displays[$];
  int      fail_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic result_t advance_timer(input op_t op, input logic up, input logic down);
    result_t    shown;
    logic [1:0] pattern;
    int         ones_digit;
    int         tens_digit;
    pattern = {down, up};
    case (op)
      OP_TICK: begin
        if (run_flag) begin
          if (tick_count > threshold) begin
            tick_count = '0;
            if (seconds_left != 0) seconds_left = seconds_left - SecW'(1);
            else buzz_flag = 1'b1;
          end else begin
            tick_count = tick_count + TickW'(1);
          end
        end
      end
      OP_START: run_flag = 1'b1;
      OP_STOP: begin
        run_flag  = 1'b0;
        buzz_flag = 1'b0;
      end
      default: begin
        if (pattern == BTN_RELEASED) begin
          last_buttons = BTN_RELEASED;
        end else if (pattern != last_buttons) begin
          last_buttons = pattern;
          if (!up) begin
            if (seconds_left < max_setting) seconds_left = seconds_left + SecW'(1);
          end else if (!down && seconds_left != 0) begin
            seconds_left = seconds_left - SecW'(1);
          end
        end
      end
    endcase
    ones_digit          = seconds_left % 10;
    tens_digit          = (seconds_left / 10) % 10;
    shown.remaining     = seconds_left;
    shown.ones_segments = DigitPatterns[8*ones_digit +: 8];
    shown.tens_segments = DigitPatterns[8*tens_digit +: 8];
    shown.buzzer        = buzz_flag;
    shown.running       = run_flag;
    return shown;
  endfunction

  task automatic report_mismatch(input result_t want, input result_t got, input bit orphan);
    fail_count++;
    if (fail_count <= 10) begin
      if (orphan)
        $display("%0t: result with no request pending: ", $realtime,
                 "remaining=%0d ones=%h tens=%h buzzer=%b running=%b",
                 got.remaining, got.ones_segments, got.tens_segments, got.buzzer,
                 got.running);
      else
        $display("%0t: result mismatch: ", $realtime,
                 "expected remaining=%0d ones=%h tens=%h buzzer=%b running=%b, ",
                 want.remaining, want.ones_segments, want.tens_segments, want.buzzer,
                 want.running,
                 "got remaining=%0d ones=%h tens=%h buzzer=%b running=%b",
                 got.remaining, got.ones_segments, got.tens_segments,
                 got.buzzer, got.running);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      threshold    = 8'd15;
      max_setting  = 7'd99;
      seconds_left = '0;
      tick_count   = '0;
      run_flag     = 1'b0;
      buzz_flag    = 1'b0;
      last_buttons = BTN_RELEASED;
      pending_displays.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PRESCALE) threshold = cfg_data;
        else max_setting = cfg_data[SecW-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (pending_displays.size() == 0) begin
          report_mismatch(got, got, 1'b1);
        end else begin
          want = pending_displays.pop_front();
          if (got.remaining !== want.remaining || got.ones_segments !== want.ones_segments ||
              got.tens_segments !== want.tens_segments || got.buzzer !== want.buzzer ||
              got.running !== want.running)
            report_mismatch(want, got, 1'b0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_displays.push_back(advance_timer(op_t'(s_axis_tuser), s_axis_tdata[0],
                                                 s_axis_tdata[1]));
      outstanding <= pending_displays.size();
    end
    mismatches <= fail_count;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the countdown_timer_buzzer testbench: drives event requests, config writes and
// result back-pressure, and gives the verdict. Depends on ctb_pkg, the block and ctb_checker.
module testbench;
  import ctb_pkg::*;

  localparam int StallLimit = 2000;
  localparam int LongHold   = 60;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] button_up_level, [1] button_down_level
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [6:0] remaining, [14:7] ones_segments,
                               // [22:15] tens_segments, [23] buzzer, [24] running
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  int items_sent   = 0;
  bit idle_on      = 1'b1;
  bit hold_done    = 1'b0;

  countdown_timer_buzzer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ctb_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input op_t op, input logic up, input logic down);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, down, up};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic set_config(input logic [7:0] threshold, input logic [6:0] max_setting);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PRESCALE;
    cfg_data  <= threshold;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MAX;
    cfg_data  <= {1'b0, max_setting};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic press_buttons(input bit going_up, input int presses);
    logic up_level;
    logic down_level;
    up_level   = going_up ? 1'b0 : 1'b1;
    down_level = going_up ? 1'b1 : 1'b0;
    for (int k = 0; k < presses; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(OP_SAMPLE, 1'b0, 1'b0);
      send_item(OP_SAMPLE, up_level, down_level);
      if ($urandom_range(0, 5) == 0) send_item(OP_SAMPLE, up_level, down_level);
      send_item(OP_SAMPLE, 1'b1, 1'b1);
    end
  endtask

  task automatic run_ticks(input int ticks);
    send_item(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (ticks) send_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0)
      send_item(OP_STOP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise(input int count);
    repeat (count)
      send_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input logic [7:0] threshold, input logic [6:0] max_setting,
                           input int up_presses, input int long_ticks, input int budget,
                           input bit idling);
    int target;
    set_config(threshold, max_setting);
    idle_on = idling;
    if (long_ticks > 0) run_ticks(long_ticks);
    press_buttons(1'b1, up_presses);
    target = items_sent + budget;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: press_buttons(1'($urandom_range(0, 1)), $urandom_range(1, 12));
        3, 4, 5, 6: run_ticks($urandom_range(1, 40));
        default: send_noise($urandom_range(1, 8));
      endcase
    end
  endtask

  // result side: random stall bursts while idling is on, and one long hold-off once 60 items are sent
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= 60) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("countdown_timer_buzzer test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_TICK;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_PRESCALE;
    cfg_data      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // buttons at reset settings: release, press, hold, both, down, floor at zero
    send_item(OP_SAMPLE, 1'b1, 1'b1);
    send_item(OP_SAMPLE, 1'b0, 1'b1);
    send_item(OP_SAMPLE, 1'b0, 1'b1);
    send_item(OP_SAMPLE, 1'b0, 1'b0);
    send_item(OP_SAMPLE, 1'b1, 1'b0);
    send_item(OP_SAMPLE, 1'b1, 1'b1);
    send_item(OP_SAMPLE, 1'b1, 1'b0);
    send_item(OP_SAMPLE, 1'b1, 1'b1);
    send_item(OP_SAMPLE, 1'b1, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0);

    // cap the value at two, then count it down to the buzzer
    set_config(8'd0, 7'd2);
    repeat (2) begin
      send_item(OP_SAMPLE, 1'b0, 1'b1);
      send_item(OP_SAMPLE, 1'b1, 1'b1);
    end
    send_item(OP_SAMPLE, 1'b0, 1'b1);
    send_item(OP_START, 1'b0, 1'b0);
    repeat (6) send_item(OP_TICK, 1'b1, 1'b1);
    send_item(OP_START, 1'b1, 1'b1);
    send_item(OP_STOP, 1'b0, 1'b1);

    run_phase(8'd0,   7'd99,  20,  0,   50, 1'b1);
    run_phase(8'd255, 7'd99,  0,   280, 30, 1'b1);
    run_phase(8'd3,   7'd127, 130, 0,   20, 1'b1);
    run_phase(8'd1,   7'd0,   3,   0,   50, 1'b0);
    run_phase(8'd2,   7'd1,   3,   0,   50, 1'b1);
    run_phase(8'd15,  7'd50,  50,  0,   40, 1'b0);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("countdown_timer_buzzer test passed");
    else
      $display("countdown_timer_buzzer test failed");
    $finish;
  end

endmodule

[countdown_timer_buzzer.f]
rtl/ctb_pkg.sv
rtl/ctb_core.sv
rtl/ctb_digits.sv
rtl/ctb_out_reg.sv
rtl/countdown_timer_buzzer.sv
rtl/ctb_checker.sv
dv/ctb_checker.sv
dv/testbench.sv
